/* rtl/mlsp_pkg.sv */
// ----------------------------------------------------------------------------
// mlsp_pkg
// Shared types and constants of the manifest log stream parser.
// ----------------------------------------------------------------------------
package mlsp_pkg;

    localparam int LEN_BITS_DEFAULT = 32;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [3:0] {
        EV_LASTSEQ  = 4'd0,
        EV_NEXTFILE = 4'd1,
        EV_ADDNUM   = 4'd2,
        EV_ADDSIZE  = 4'd3,
        EV_SKLEN    = 4'd4,
        EV_SKBYTE   = 4'd5,
        EV_LKLEN    = 4'd6,
        EV_LKBYTE   = 4'd7,
        EV_DELETE   = 4'd8,
        EV_ACCEPT   = 4'd9,
        EV_ERROR    = 4'd10
    } event_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CRC_SHORT = 3'd1,
        ERR_LEN_BAD   = 3'd2,
        ERR_PAY_SHORT = 3'd3,
        ERR_CRC_BAD   = 3'd4,
        ERR_FIELD     = 3'd5,
        ERR_TAG       = 3'd6
    } error_code_t;

    typedef enum logic [12:0] {
        PH_HDR      = 13'b0_0000_0000_0001,
        PH_LEN      = 13'b0_0000_0000_0010,
        PH_TAG      = 13'b0_0000_0000_0100,
        PH_LASTSEQ  = 13'b0_0000_0000_1000,
        PH_NEXTFILE = 13'b0_0000_0001_0000,
        PH_ADDNUM   = 13'b0_0000_0010_0000,
        PH_ADDSIZE  = 13'b0_0000_0100_0000,
        PH_SKLEN    = 13'b0_0000_1000_0000,
        PH_SKBYTE   = 13'b0_0001_0000_0000,
        PH_LKLEN    = 13'b0_0010_0000_0000,
        PH_LKBYTE   = 13'b0_0100_0000_0000,
        PH_DELETE   = 13'b0_1000_0000_0000,
        PH_SKIP     = 13'b1_0000_0000_0000
    } phase_t;

    typedef struct packed {
        event_kind_t kind;
        logic [63:0] value;
        error_code_t err;
    } event_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* rtl/manifest_log_stream_parser.sv */
// ----------------------------------------------------------------------------
// manifest_log_stream_parser
// Parses CRC-checked, varint-framed records from a log byte stream into events.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, back to back, as long as each byte yields at most
// one event beat and the receiver keeps up. Each byte yields zero, one or two
// event beats. The events of a byte are formed in the same cycle as the byte is
// taken and placed in a two-entry output buffer. The input stalls whenever that
// buffer will not be empty at the next edge. A byte that yields two beats
// therefore holds off the next byte until its second beat leaves the buffer,
// and every cycle the receiver stalls a waiting beat also stalls the input.
// The CRC update and varint step of a byte are combinational.
module manifest_log_stream_parser
    import mlsp_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_kind,
    output logic [63:0] event_value,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    localparam int QW = $bits(event_t) + 1;

    phase_t            phase_reg, phase_next;
    logic [1:0]        hcnt_reg, hcnt_next;
    logic [31:0]       scrc_reg, scrc_next;
    logic [31:0]       rcrc_reg, rcrc_next;
    logic [63:0]       acc_reg, acc_next;
    logic [3:0]        vcnt_reg, vcnt_next;
    logic [LEN_BITS-1:0] pay_reg, pay_next;
    logic [LEN_BITS-1:0] key_reg, key_next;
    logic              latch_reg, latch_next;
    error_code_t       perr_reg, perr_next;

    // Output buffer: two entries of {event, last}.
    logic [QW-1:0]     q_reg [2];
    logic [1:0]        qn_reg;

    logic   take;
    event_t ev0, ev1;
    logic   v0, v1;

    assign in_stall = (qn_reg != 2'd0) && !(qn_reg == 2'd1 && out_valid && !out_stall);
    assign take = in_valid && !in_stall;

    // Varint step signals.
    logic [63:0] acc_add;
    logic [3:0]  cnt_add;
    logic        v_done, v_long;
    logic [6:0]  sh;
    logic [LEN_BITS-1:0] pay_dec, key_dec;
    logic [31:0] crc_new;

    always_comb
    begin
        sh = 7'(7 * vcnt_reg);
        acc_add = acc_reg;
        if (vcnt_reg < 4'd10)
        begin
            acc_add = acc_reg | (64'(data_byte[6:0]) << sh);
        end
        cnt_add = vcnt_reg + 4'd1;
        v_done = !data_byte[7];
        v_long = data_byte[7] && (cnt_add >= 4'd10);
        pay_dec = pay_reg - LEN_BITS'(1);
        key_dec = key_reg - LEN_BITS'(1);
        crc_new = crc_byte(rcrc_reg, data_byte);
    end

    function automatic logic fits(input logic [63:0] v);
        if (LEN_BITS >= 64)
        begin
            return 1'b1;
        end
        return (v >> LEN_BITS) == 64'd0;
    endfunction

    always_comb
    begin
        logic failed;
        logic fin;
        error_code_t ferr;
        event_t e;
        phase_t ph;
        phase_next = phase_reg;
        hcnt_next  = hcnt_reg;
        scrc_next  = scrc_reg;
        rcrc_next  = rcrc_reg;
        acc_next   = acc_reg;
        vcnt_next  = vcnt_reg;
        pay_next   = pay_reg;
        key_next   = key_reg;
        latch_next = latch_reg;
        perr_next  = perr_reg;
        ev0 = '0; ev1 = '0; v0 = 1'b0; v1 = 1'b0;
        failed = 1'b0;
        fin = 1'b0;
        ferr = ERR_NONE;
        e = '0;
        ph = phase_reg;
        if (latch_reg)
        begin
            if (end_of_stream)
            begin
                latch_next = 1'b0;
                phase_next = PH_HDR; hcnt_next = '0; scrc_next = '0;
                rcrc_next = CRC_INIT; acc_next = '0; vcnt_next = '0;
                pay_next = '0; key_next = '0; perr_next = ERR_NONE;
            end
        end
        else
        begin
            if (phase_reg == PH_HDR)
            begin
                scrc_next = scrc_reg | (32'(data_byte) << {hcnt_reg, 3'b000});
                if (hcnt_reg == 2'd3)
                begin
                    phase_next = PH_LEN; hcnt_next = '0; rcrc_next = CRC_INIT;
                    acc_next = '0; vcnt_next = '0;
                end
                else
                begin
                    hcnt_next = hcnt_reg + 2'd1;
                end
            end
            else if (phase_reg == PH_LEN)
            begin
                rcrc_next = crc_new;
                acc_next = acc_add;
                vcnt_next = cnt_add;
                if (v_long || (v_done && !fits(acc_add)))
                begin
                    ev0 = '{EV_ERROR, 64'd0, ERR_LEN_BAD}; v0 = 1'b1; failed = 1'b1;
                end
                else if (v_done)
                begin
                    pay_next = acc_add[LEN_BITS-1:0];
                    acc_next = '0; vcnt_next = '0;
                    if (acc_add == 64'd0)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TAG;
                    end
                end
            end
            else
            begin
                rcrc_next = crc_new;
                pay_next = pay_dec;
                case (phase_reg)
                    PH_SKIP: ;
                    PH_TAG:
                    begin
                        acc_next = '0; vcnt_next = '0;
                        case (data_byte)
                            8'd1: phase_next = PH_LASTSEQ;
                            8'd2: phase_next = PH_NEXTFILE;
                            8'd3: phase_next = PH_ADDNUM;
                            8'd4: phase_next = PH_DELETE;
                            default:
                            begin
                                perr_next = ERR_TAG; phase_next = PH_SKIP;
                            end
                        endcase
                    end
                    PH_SKBYTE, PH_LKBYTE:
                    begin
                        ev0 = '{(phase_reg == PH_SKBYTE) ? EV_SKBYTE : EV_LKBYTE,
                                64'(data_byte), ERR_NONE};
                        v0 = 1'b1;
                        key_next = key_dec;
                        if (key_dec == '0)
                        begin
                            phase_next = (phase_reg == PH_SKBYTE) ? PH_LKLEN : PH_TAG;
                            acc_next = '0; vcnt_next = '0;
                        end
                    end
                    default:
                    begin
                        acc_next = acc_add;
                        vcnt_next = cnt_add;
                        if (v_long)
                        begin
                            perr_next = ERR_FIELD; phase_next = PH_SKIP;
                        end
                        else if (v_done)
                        begin
                            e.value = acc_add;
                            e.err = ERR_NONE;
                            case (phase_reg)
                                PH_LASTSEQ:  e.kind = EV_LASTSEQ;
                                PH_NEXTFILE: e.kind = EV_NEXTFILE;
                                PH_ADDNUM:   e.kind = EV_ADDNUM;
                                PH_ADDSIZE:  e.kind = EV_ADDSIZE;
                                PH_SKLEN:    e.kind = EV_SKLEN;
                                PH_LKLEN:    e.kind = EV_LKLEN;
                                default:     e.kind = EV_DELETE;
                            endcase
                            ev0 = e; v0 = 1'b1;
                            acc_next = '0; vcnt_next = '0;
                            case (phase_reg)
                                PH_SKLEN, PH_LKLEN:
                                begin
                                    // Compared against the count left after this byte.
                                    if (!fits(acc_add) ||
                                        acc_add[LEN_BITS-1:0] > pay_dec)
                                    begin
                                        perr_next = ERR_FIELD; phase_next = PH_SKIP;
                                        acc_next = acc_add; vcnt_next = cnt_add;
                                    end
                                    else
                                    begin
                                        key_next = acc_add[LEN_BITS-1:0];
                                        if (acc_add != 64'd0)
                                        begin
                                            phase_next = (phase_reg == PH_SKLEN) ?
                                                         PH_SKBYTE : PH_LKBYTE;
                                        end
                                        else
                                        begin
                                            phase_next = (phase_reg == PH_SKLEN) ?
                                                         PH_LKLEN : PH_TAG;
                                        end
                                    end
                                end
                                PH_ADDNUM:  phase_next = PH_ADDSIZE;
                                PH_ADDSIZE: phase_next = PH_SKLEN;
                                default:    phase_next = PH_TAG;
                            endcase
                        end
                    end
                endcase
                if (pay_dec == '0)
                begin
                    fin = 1'b1;
                end
            end
            if (fin)
            begin
                ph = phase_next;
                if (~rcrc_next != scrc_reg)
                begin
                    ferr = ERR_CRC_BAD;
                end
                else if (perr_next != ERR_NONE)
                begin
                    ferr = perr_next;
                end
                else if (ph != PH_TAG && ph != PH_SKIP && ph != PH_LEN)
                begin
                    ferr = ERR_FIELD;
                end
                if (ferr != ERR_NONE)
                begin
                    e = '{EV_ERROR, 64'd0, ferr};
                end
                else
                begin
                    e = '{EV_ACCEPT, 64'd0, ERR_NONE};
                end
                if (v0)
                begin
                    ev1 = e; v1 = 1'b1;
                end
                else
                begin
                    ev0 = e; v0 = 1'b1;
                end
                if (ferr != ERR_NONE)
                begin
                    failed = 1'b1;
                end
                else
                begin
                    phase_next = PH_HDR; hcnt_next = '0; scrc_next = '0;
                    rcrc_next = CRC_INIT; acc_next = '0; vcnt_next = '0;
                    pay_next = '0; key_next = '0; perr_next = ERR_NONE;
                end
            end
            if (end_of_stream && !failed && !(phase_next == PH_HDR && hcnt_next == 2'd0))
            begin
                e = '{EV_ERROR, 64'd0,
                      (phase_next == PH_HDR) ? ERR_CRC_SHORT :
                      (phase_next == PH_LEN) ? ERR_LEN_BAD : ERR_PAY_SHORT};
                if (v0)
                begin
                    ev1 = e; v1 = 1'b1;
                end
                else
                begin
                    ev0 = e; v0 = 1'b1;
                end
                failed = 1'b1;
            end
            if (end_of_stream)
            begin
                latch_next = 1'b0;
                phase_next = PH_HDR; hcnt_next = '0; scrc_next = '0;
                rcrc_next = CRC_INIT; acc_next = '0; vcnt_next = '0;
                pay_next = '0; key_next = '0; perr_next = ERR_NONE;
            end
            else if (failed)
            begin
                latch_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            hcnt_reg  <= '0;
            scrc_reg  <= '0;
            rcrc_reg  <= CRC_INIT;
            acc_reg   <= '0;
            vcnt_reg  <= '0;
            pay_reg   <= '0;
            key_reg   <= '0;
            latch_reg <= 1'b0;
            perr_reg  <= ERR_NONE;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            scrc_reg  <= scrc_next;
            rcrc_reg  <= rcrc_next;
            acc_reg   <= acc_next;
            vcnt_reg  <= vcnt_next;
            pay_reg   <= pay_next;
            key_reg   <= key_next;
            latch_reg <= latch_next;
            perr_reg  <= perr_next;
        end
    end

    // Output buffer. A beat is popped from entry 0; new beats land behind it.
    logic pop;
    logic [1:0] base;
    assign out_valid = (qn_reg != 2'd0);
    assign pop = out_valid && !out_stall;
    assign base = qn_reg - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qn_reg <= '0;
        end
        else
        begin
            qn_reg <= base + ((take && v0) ? 2'd1 : 2'd0) + ((take && v1) ? 2'd1 : 2'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            q_reg[0] <= q_reg[1];
        end
        if (take && v0)
        begin
            if (base == 2'd0)
            begin
                q_reg[0] <= {ev0, !v1};
                if (v1)
                begin
                    q_reg[1] <= {ev1, 1'b1};
                end
            end
            else
            begin
                q_reg[1] <= {ev0, 1'b1};
            end
        end
    end

    assign event_kind  = q_reg[0][QW-1 -: 4];
    assign event_value = q_reg[0][QW-5 -: 64];
    assign error_code  = q_reg[0][3:1];
    assign last_of_run = q_reg[0][0];

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (qn_reg == 2'd2) |-> !take)
        else $error("byte taken with full output buffer");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        qn_reg != 2'd3)
        else $error("output buffer overflow");
    a_two_need_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (take && v1) |-> (base == 2'd0))
        else $error("two beats without room");

endmodule
